>>> src/rtss_pkg.sv
// ----------------------------------------------------------------------------
// Record table package
// Operation, key and status codes, the queued command type and engine states.
// ----------------------------------------------------------------------------
package rtss_pkg;

   localparam int unsigned OpWidth   = 3;
   localparam int unsigned KeyWidth  = 2;
   localparam int unsigned NameWidth = 64;
   localparam int unsigned YearWidth = 16;
   localparam int unsigned VolWidth  = 8;
   localparam int unsigned PriceWidth = 32;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_REMOVE = 3'd1,
      OP_SORT   = 3'd2,
      OP_FIND   = 3'd3,
      OP_DUMP   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      KEY_NAME   = 2'd0,
      KEY_YEAR   = 2'd1,
      KEY_VOLUME = 2'd2,
      KEY_PRICE  = 2'd3
   } key_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      op_type                  op;
      key_type                 key;
      logic [NameWidth-1:0]    name;
      logic [YearWidth-1:0]    year;
      logic [VolWidth-1:0]     vol;
      logic [PriceWidth-1:0]   price;
   } cmd_type;

   typedef struct packed {
      status_type              status;
      logic [NameWidth-1:0]    name;
      logic [YearWidth-1:0]    year;
      logic [VolWidth-1:0]     vol;
      logic [PriceWidth-1:0]   price;
      logic                    last;
   } rsp_type;

   typedef enum logic [3:0] {
      EN_IDLE,
      EN_DISPATCH,
      EN_SCAN_RD,
      EN_SCAN_CHK,
      EN_SHIFT_RD,
      EN_SHIFT_WR,
      EN_SORT_RD,
      EN_SORT_CHK,
      EN_SORT_WR,
      EN_DUMP_RD,
      EN_DUMP_OUT,
      EN_EMIT
   } eng_state_type;

endpackage

>>> src/rtss_front.sv
// ----------------------------------------------------------------------------
// Record table front end
// Accepts requests, drops unknown operations and masks the name, then queues
// the command for the engine in a small FIFO.
// ----------------------------------------------------------------------------
module rtss_front
   import rtss_pkg::*;
#(
   parameter int unsigned NAME_BYTES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [OpWidth-1:0]    req_op,
   input  logic [KeyWidth-1:0]   req_key,
   input  logic [NameWidth-1:0]  req_name,
   input  logic [YearWidth-1:0]  req_year,
   input  logic [VolWidth-1:0]   req_vol,
   input  logic [PriceWidth-1:0] req_price,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output cmd_type               cmd_data
);

   localparam int unsigned QDepth = 2;
   localparam logic [NameWidth-1:0] NameMask = {NameWidth{1'b1}} >> (64 - 8 * NAME_BYTES);

   cmd_type    q_mem [QDepth];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop, known;
   cmd_type    new_cmd;

   assign known     = (req_op <= OP_DUMP);
   assign req_tready = (cnt_ff != 2'(QDepth));
   assign push      = req_tvalid && req_tready && known;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd_data  = q_mem[rd_ptr_ff];

   always_comb begin
      new_cmd.op    = op_type'(req_op);
      new_cmd.key   = key_type'(req_key);
      new_cmd.name  = req_name & NameMask;
      new_cmd.year  = req_year;
      new_cmd.vol   = req_vol;
      new_cmd.price = req_price;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= new_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QDepth)) else $error("command queue overflow");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("queue count");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> !pop) else $error("pop from empty queue");

endmodule

>>> src/rtss_engine.sv
// ----------------------------------------------------------------------------
// Record table engine
// Executes one command at a time against the record memory and drives a
// one-entry output register.
// ----------------------------------------------------------------------------
module rtss_engine
   import rtss_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
   localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned RecW = NameWidth + YearWidth + VolWidth + PriceWidth;

   typedef struct packed {
      logic [NameWidth-1:0]  name;
      logic [YearWidth-1:0]  year;
      logic [VolWidth-1:0]   vol;
      logic [PriceWidth-1:0] price;
   } rec_type;

   rec_type mem [TABLE_DEPTH];

   eng_state_type st_ff, st_in;
   cmd_type       cmd_ff, cmd_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] i_ff, i_in, j_ff, j_in;
   rec_type       ra_ff, rb_ff;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_ff, out_in;
   // Single-result commands stage their result here until the output
   // register is free.
   rsp_type       hold_ff, hold_in;

   logic          we;
   logic [IdxW-1:0] waddr, addr_a, addr_b;
   rec_type       wdata;
   logic          we2;
   logic [IdxW-1:0] waddr2;
   rec_type       wdata2;

   function automatic logic [NameWidth-1:0] key_of(rec_type r, key_type k);
      logic [NameWidth-1:0] v;
      v = '0;
      case (k)
         KEY_NAME:   v = r.name;
         KEY_YEAR:   v = NameWidth'(r.year);
         KEY_VOLUME: v = NameWidth'(r.vol);
         default:    v = NameWidth'(r.price);
      endcase
      return v;
   endfunction

   function automatic rsp_type mk_rsp(status_type s, rec_type r);
      rsp_type o;
      o.status = s;
      o.name   = r.name;
      o.year   = r.year;
      o.vol    = r.vol;
      o.price  = r.price;
      o.last   = 1'b1;
      return o;
   endfunction

   logic [NameWidth-1:0] want;
   always_comb begin
      case (cmd_ff.key)
         KEY_NAME:   want = cmd_ff.name;
         KEY_YEAR:   want = NameWidth'(cmd_ff.year);
         KEY_VOLUME: want = NameWidth'(cmd_ff.vol);
         default:    want = NameWidth'(cmd_ff.price);
      endcase
   end

   logic [RecW-1:0] zero_rec;
   assign zero_rec = '0;
   assign cmd_ready = (st_ff == EN_IDLE);
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   always_comb begin
      st_in = st_ff;
      cmd_in = cmd_ff;
      count_in = count_ff;
      i_in = i_ff;
      j_in = j_ff;
      hold_in = hold_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff && !out_ready;
      we = 1'b0; waddr = i_ff[IdxW-1:0]; wdata = ra_ff;
      we2 = 1'b0; waddr2 = j_ff[IdxW-1:0]; wdata2 = rb_ff;
      addr_a = i_ff[IdxW-1:0];
      addr_b = j_ff[IdxW-1:0];
      unique case (st_ff)
         EN_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd_data;
               st_in = EN_DISPATCH;
            end
         end
         EN_DISPATCH: begin
            i_in = '0;
            j_in = CntW'(1);
            unique case (cmd_ff.op)
               OP_ADD: begin
                  if (count_ff == CntW'(TABLE_DEPTH)) begin
                     hold_in = mk_rsp(ST_FULL, rec_type'(zero_rec));
                  end else begin
                     we = 1'b1;
                     waddr = count_ff[IdxW-1:0];
                     wdata = rec_type'({cmd_ff.name, cmd_ff.year, cmd_ff.vol,
                                        cmd_ff.price});
                     count_in = count_ff + 1'b1;
                     hold_in = mk_rsp(ST_OK, wdata);
                  end
                  st_in = EN_EMIT;
               end
               OP_REMOVE, OP_FIND: begin
                  st_in = EN_SCAN_RD;
               end
               OP_SORT: begin
                  st_in = EN_SORT_RD;
               end
               OP_DUMP: begin
                  if (count_ff == '0) begin
                     hold_in = mk_rsp(ST_EMPTY, rec_type'(zero_rec));
                     st_in = EN_EMIT;
                  end else begin
                     st_in = EN_DUMP_RD;
                  end
               end
               default: st_in = EN_IDLE;
            endcase
         end
         EN_SCAN_RD: begin
            if (i_ff >= count_ff) begin
               hold_in = mk_rsp(ST_NOT_FOUND, rec_type'(zero_rec));
               st_in = EN_EMIT;
            end else begin
               st_in = EN_SCAN_CHK;
            end
         end
         EN_SCAN_CHK: begin
            if (key_of(ra_ff, (cmd_ff.op == OP_REMOVE) ? KEY_NAME : cmd_ff.key) ==
                ((cmd_ff.op == OP_REMOVE) ? cmd_ff.name : want)) begin
               hold_in = mk_rsp(ST_OK, ra_ff);
               if (cmd_ff.op == OP_REMOVE) begin
                  j_in = i_ff + 1'b1;
                  st_in = EN_SHIFT_RD;
               end else begin
                  st_in = EN_EMIT;
               end
            end else begin
               i_in = i_ff + 1'b1;
               st_in = EN_SCAN_RD;
            end
         end
         EN_SHIFT_RD: begin
            if (j_ff >= count_ff) begin
               count_in = count_ff - 1'b1;
               st_in = EN_EMIT;
            end else begin
               st_in = EN_SHIFT_WR;
            end
         end
         EN_SHIFT_WR: begin
            we = 1'b1;
            waddr = i_ff[IdxW-1:0];
            wdata = rb_ff;
            i_in = j_ff;
            j_in = j_ff + 1'b1;
            st_in = EN_SHIFT_RD;
         end
         EN_SORT_RD: begin
            if (j_ff >= count_ff) begin
               if (i_ff + 2'd2 >= count_ff) begin
                  hold_in = mk_rsp(ST_OK, rec_type'(zero_rec));
                  st_in = EN_EMIT;
               end else begin
                  i_in = i_ff + 1'b1;
                  j_in = i_ff + 2'd2;
               end
            end else begin
               st_in = EN_SORT_CHK;
            end
         end
         EN_SORT_CHK: begin
            if (key_of(ra_ff, cmd_ff.key) > key_of(rb_ff, cmd_ff.key)) begin
               st_in = EN_SORT_WR;
            end else begin
               j_in = j_ff + 1'b1;
               st_in = EN_SORT_RD;
            end
         end
         EN_SORT_WR: begin
            we = 1'b1; waddr = i_ff[IdxW-1:0]; wdata = rb_ff;
            we2 = 1'b1; waddr2 = j_ff[IdxW-1:0]; wdata2 = ra_ff;
            j_in = j_ff + 1'b1;
            st_in = EN_SORT_RD;
         end
         EN_DUMP_RD: begin
            if (!out_valid_ff || out_ready) st_in = EN_DUMP_OUT;
         end
         EN_DUMP_OUT: begin
            out_in = mk_rsp(ST_OK, ra_ff);
            out_in.last = (i_ff + 1'b1 == count_ff);
            out_valid_in = 1'b1;
            i_in = i_ff + 1'b1;
            st_in = (i_ff + 1'b1 == count_ff) ? EN_IDLE : EN_DUMP_RD;
         end
         EN_EMIT: begin
            if (!out_valid_ff || out_ready) begin
               out_in = hold_ff;
               out_valid_in = 1'b1;
               st_in = EN_IDLE;
            end
         end
         default: st_in = EN_IDLE;
      endcase
   end

   // Record memory: one write port, two registered read ports. A swap writes
   // the second entry on the following cycle through a separate path.
   logic           swap2_ff;
   logic [IdxW-1:0] swap2_addr_ff;
   rec_type        swap2_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end else if (swap2_ff) begin
         mem[swap2_addr_ff] <= swap2_data_ff;
      end
      ra_ff <= mem[addr_a];
      rb_ff <= mem[addr_b];
      swap2_addr_ff <= waddr2;
      swap2_data_ff <= wdata2;
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      hold_ff <= hold_in;
      out_ff  <= out_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= EN_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         swap2_ff     <= 1'b0;
      end else begin
         st_ff        <= st_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         swap2_ff     <= we2;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(TABLE_DEPTH)) else $error("entry count overflow");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ready) |=> out_valid_ff && $stable(out_ff))
      else $error("result dropped");
   a_swap_free: assert property (@(posedge clock) disable iff (reset)
      we2 |=> !we) else $error("swap write collides");

endmodule

>>> src/record_table_sort_search_top.sv
// ----------------------------------------------------------------------------
// Record table with sort and search
// Top level: request FIFO front end and table engine.
// ----------------------------------------------------------------------------
// Each request transfer carries one operation: add, remove by name, sort,
// find or dump. Requests enter a two-entry queue, so a new request is taken
// while the engine works. The engine handles one request at a time over a
// record memory with one write port and two registered read ports. Add appends
// the record unless the table is full; remove and find scan the entries in
// order, and a removal then shifts the later entries down one place; sort
// compares pairs of entries and swaps those out of order; dump gives one
// record transfer per entry with tlast on the final one. Operation codes 5
// to 7 are dropped. The result register holds one transfer and stalls only
// the engine.
module record_table_sort_search_top
   import rtss_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 32,
   parameter int unsigned NAME_BYTES  = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // operation[2:0], key_select[4:3], name_key[68:5], model_year[84:69],
   // volume_tenths[92:85], price_units[124:93], zero fill [127:125]
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], out_name[65:2], out_year[81:66], out_volume[89:82],
   // out_price[121:90], zero fill [127:122]
   output logic [127:0] rsp_tdata,
   output logic         rsp_tlast
);

   logic    cmd_valid, cmd_ready;
   cmd_type cmd_data;
   rsp_type rsp;

   rtss_front #(.NAME_BYTES(NAME_BYTES)) u_front (
      .clock, .reset,
      .req_tvalid, .req_tready,
      .req_op(req_tdata[2:0]),
      .req_key(req_tdata[4:3]),
      .req_name(req_tdata[68:5]),
      .req_year(req_tdata[84:69]),
      .req_vol(req_tdata[92:85]),
      .req_price(req_tdata[124:93]),
      .cmd_valid, .cmd_ready, .cmd_data
   );

   rtss_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
      .clock, .reset,
      .cmd_valid, .cmd_ready, .cmd_data,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(rsp)
   );

   assign rsp_tdata = {6'd0, rsp.price, rsp.vol, rsp.year, rsp.name, rsp.status};
   assign rsp_tlast = rsp.last;

endmodule
